// ----- rtl/salc_pkg.sv -----
// Shared types, constants and codes for the set-associative LRU cache model.
`default_nettype none

package salc_pkg;

    // Default geometry handed to the top level as parameter defaults.
    localparam int DEF_MAX_SET_BITS = 8;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_STAMP_BITS   = 32;

    // Fixed field widths.
    localparam int OP_W      = 2;
    localparam int ADDR_W    = 64;
    localparam int TAG_W     = 62;
    localparam int CNT_W     = 32;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int SETB_W    = 4;
    localparam int WAYSR_W   = 4;
    localparam int OFFB_W    = 6;

    // Access kinds. The unused code behaves as a load.
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd2;

    // Configuration reset values.
    localparam logic [SETB_W-1:0]  RST_SET_BITS    = 4'd4;
    localparam logic [WAYSR_W-1:0] RST_WAYS        = 4'd1;
    localparam logic [OFFB_W-1:0]  RST_OFFSET_BITS = 6'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_FINISH
    } salc_state_t;

    // Sequencer to scan unit.
    typedef struct packed {
        logic step;
        logic first;
    } scan_ctl_t;

    // Scan unit back to sequencer.
    typedef struct packed {
        logic hit;
        logic free;
    } scan_stat_t;

endpackage

`default_nettype wire

// ----- rtl/salc_scan_unit.sv -----
// Shared way compare unit: tag match, first free way and oldest stamp, one way per cycle.
`default_nettype none

module salc_scan_unit #(
    parameter int MAX_WAYS   = salc_pkg::DEF_MAX_WAYS,
    parameter int STAMP_BITS = salc_pkg::DEF_STAMP_BITS,
    parameter int WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire salc_pkg::scan_ctl_t        ctl,
    input  wire logic [WAY_W-1:0]           way,
    input  wire logic                       line_valid,
    input  wire logic [salc_pkg::TAG_W-1:0] line_tag,
    input  wire logic [salc_pkg::TAG_W-1:0] ref_tag,
    input  wire logic [STAMP_BITS-1:0]      line_stamp,
    input  wire logic [STAMP_BITS-1:0]      now,
    output salc_pkg::scan_stat_t            status,
    output logic [WAY_W-1:0]                pick_way
);
    import salc_pkg::*;

    logic                  match;
    logic [STAMP_BITS-1:0] age;

    logic                  hit_reg, hit_next;
    logic                  free_reg, free_next;
    logic [WAY_W-1:0]      hit_way_reg, hit_way_next;
    logic [WAY_W-1:0]      free_way_reg, free_way_next;
    logic [WAY_W-1:0]      best_way_reg, best_way_next;
    logic [STAMP_BITS-1:0] best_age_reg, best_age_next;

    assign match = line_valid && (line_tag == ref_tag);
    // Age wraps with the stamp counter.
    assign age   = now - line_stamp;

    always_comb begin
        hit_next      = hit_reg;
        free_next     = free_reg;
        hit_way_next  = hit_way_reg;
        free_way_next = free_way_reg;
        best_way_next = best_way_reg;
        best_age_next = best_age_reg;
        if (ctl.step) begin
            if (ctl.first) begin
                hit_next      = match;
                hit_way_next  = way;
                free_next     = !line_valid;
                free_way_next = way;
                best_age_next = age;
                best_way_next = way;
            end else begin
                if (!hit_reg && match) begin
                    hit_next     = 1'b1;
                    hit_way_next = way;
                end
                if (!free_reg && !line_valid) begin
                    free_next     = 1'b1;
                    free_way_next = way;
                end
                // Strictly greater keeps ties on the lowest way.
                if (age > best_age_reg) begin
                    best_age_next = age;
                    best_way_next = way;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end else begin
            hit_reg  <= hit_next;
            free_reg <= free_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_way_reg  <= hit_way_next;
        free_way_reg <= free_way_next;
        best_way_reg <= best_way_next;
        best_age_reg <= best_age_next;
    end

    assign status.hit  = hit_reg;
    assign status.free = free_reg;
    assign pick_way    = hit_reg ? hit_way_reg : (free_reg ? free_way_reg : best_way_reg);

endmodule

`default_nettype wire

// ----- rtl/set_assoc_lru_cache_sim.sv -----
// Top level of the tag-only set-associative cache with LRU replacement.
//
//   channel   direction  handshake          word
//   s_        in         s_valid/s_ready    s_opcode, s_address
//   m_        out        m_valid/m_ready    m_hit, m_eviction, m_modify_hit, m_total_*
//   cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// An access runs in order through the sequencer states: one to split the
// address, one step per way through the shared compare unit (one read
// port on the line store), and one to choose, write back and show the result.
// The sequencer is idle again when the result appears, so a new word is
// taken only after the previous result has appeared.
// After reset a clearing pass runs over all 2**MAX_SET_BITS valid rows, one set
// per cycle, before the first word is accepted. A word is taken only while the
// sequencer is idle; a result held by a stalled m_ready does not stop
// acceptance, but the next write-back waits for the output to drain.
`default_nettype none

module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS,
    parameter int STAMP_BITS   = salc_pkg::DEF_STAMP_BITS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input words.
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [salc_pkg::OP_W-1:0]      s_opcode,
    input  wire logic [salc_pkg::ADDR_W-1:0]    s_address,
    // Result words.
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_hit,
    output logic                                m_eviction,
    output logic                                m_modify_hit,
    output logic [salc_pkg::CNT_W-1:0]          m_total_hits,
    output logic [salc_pkg::CNT_W-1:0]          m_total_misses,
    output logic [salc_pkg::CNT_W-1:0]          m_total_evictions,
    // Configuration writes.
    input  wire logic                           cfg_we,
    input  wire logic [salc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [salc_pkg::CFG_W-1:0]     cfg_wdata
);
    import salc_pkg::*;

    localparam int SET_W     = MAX_SET_BITS;
    localparam int NUM_SETS  = 1 << MAX_SET_BITS;
    localparam int NUM_LINES = NUM_SETS * MAX_WAYS;
    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAYC_W    = $clog2(MAX_WAYS + 1);
    localparam int LINE_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int SBC_W     = $clog2(MAX_SET_BITS + 1);

    // Configuration registers.
    logic [SETB_W-1:0]  set_bits_reg;
    logic [WAYSR_W-1:0] ways_reg;
    logic [OFFB_W-1:0]  off_bits_reg;

    // Register values brought into their legal ranges.
    logic [SBC_W-1:0]   sbits_c;
    logic [WAYC_W-1:0]  ways_c;
    logic [OFFB_W-1:0]  obits_c;
    logic [SET_W:0]     set_span;
    logic [SET_W-1:0]   set_mask;

    // Sequencer state and per-access registers.
    salc_state_t        state_reg, state_next;
    logic [SET_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [WAY_W-1:0]   way_reg, way_next;
    logic [ADDR_W-1:0]  shifted_reg, shifted_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [SET_W-1:0]   set_reg, set_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;

    // Line store: tag and stamp per line, valid bits per set row.
    logic [TAG_W-1:0]      tag_mem   [NUM_LINES];
    logic [STAMP_BITS-1:0] stamp_mem [NUM_LINES];
    logic [MAX_WAYS-1:0]   vrow_mem  [NUM_SETS];
    logic [TAG_W-1:0]      rd_tag_reg;
    logic [STAMP_BITS-1:0] rd_stamp_reg;
    logic [MAX_WAYS-1:0]   vrow_reg;

    logic                  line_rd_en;
    logic [SET_W-1:0]      line_rd_set;
    logic [WAY_W-1:0]      line_rd_way;
    logic [LINE_W-1:0]     line_rd_addr;
    logic                  line_we;
    logic [LINE_W-1:0]     line_wr_addr;
    logic                  vrow_rd_en;
    logic [SET_W-1:0]      vrow_rd_addr;
    logic                  vrow_we;
    logic [SET_W-1:0]      vrow_wr_addr;
    logic [MAX_WAYS-1:0]   vrow_wr_data;

    // Scan unit connection.
    scan_ctl_t             scan_ctl;
    scan_stat_t            scan_stat;
    logic [WAY_W-1:0]      pick_way;
    logic [MAX_WAYS-1:0]   pick_bit;
    logic                  finish;

    // Running totals and the stamp counter.
    logic [STAMP_BITS-1:0] access_cnt_reg;
    logic [CNT_W-1:0]      hit_cnt_reg, miss_cnt_reg, evict_cnt_reg;
    logic [CNT_W-1:0]      hit_cnt_next, miss_cnt_next, evict_cnt_next;
    logic [CNT_W:0]        hit_sum, miss_sum, evict_sum;
    logic [1:0]            hit_inc;
    logic                  modify;
    logic                  evicted;

    // Output register.
    logic m_valid_reg, m_valid_next;
    logic m_hit_reg, m_eviction_reg, m_modify_hit_reg;

    // ------------------------------------------------------------------
    // Configuration port. Unknown indexes are dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg <= RST_SET_BITS;
            ways_reg     <= RST_WAYS;
            off_bits_reg <= RST_OFFSET_BITS;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SET_BITS:    set_bits_reg <= cfg_wdata[SETB_W-1:0];
                REG_WAYS:        ways_reg     <= cfg_wdata[WAYSR_W-1:0];
                REG_OFFSET_BITS: off_bits_reg <= cfg_wdata[OFFB_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero acts as one in every register; set bits and ways are capped at the
    // size of the store.
    always_comb begin
        if (set_bits_reg == '0) begin
            sbits_c = SBC_W'(1);
        end else if (int'(set_bits_reg) > MAX_SET_BITS) begin
            sbits_c = SBC_W'(MAX_SET_BITS);
        end else begin
            sbits_c = SBC_W'(set_bits_reg);
        end
        if (ways_reg == '0) begin
            ways_c = WAYC_W'(1);
        end else if (int'(ways_reg) > MAX_WAYS) begin
            ways_c = WAYC_W'(MAX_WAYS);
        end else begin
            ways_c = WAYC_W'(ways_reg);
        end
        obits_c = (off_bits_reg == '0) ? OFFB_W'(1) : off_bits_reg;
    end

    assign set_span = (SET_W + 1)'(1) << sbits_c;
    assign set_mask = SET_W'(set_span - 1'b1);

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        way_next     = way_reg;
        shifted_next = shifted_reg;
        op_next      = op_reg;
        set_next     = set_reg;
        tag_next     = tag_reg;
        line_rd_en   = 1'b0;
        line_rd_set  = set_reg;
        line_rd_way  = WAY_W'(way_reg + 1'b1);
        line_we      = 1'b0;
        vrow_rd_en   = 1'b0;
        vrow_rd_addr = set_reg;
        vrow_we      = 1'b0;
        vrow_wr_addr = set_reg;
        vrow_wr_data = vrow_reg | pick_bit;
        scan_ctl     = '0;
        finish       = 1'b0;
        s_ready      = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                // One valid row cleared per cycle after reset.
                vrow_we      = 1'b1;
                vrow_wr_addr = clr_cnt_reg;
                vrow_wr_data = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    // The offset is stripped on the way in.
                    shifted_next = s_address >> obits_c;
                    op_next      = s_opcode;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE: begin
                // Bits beyond the 64-bit address shift in as zero, so a tag
                // that starts past the top comes out zero.
                set_next     = shifted_reg[SET_W-1:0] & set_mask;
                tag_next     = TAG_W'(shifted_reg >> sbits_c);
                vrow_rd_en   = 1'b1;
                vrow_rd_addr = set_next;
                line_rd_en   = 1'b1;
                line_rd_set  = set_next;
                line_rd_way  = '0;
                way_next     = '0;
                state_next   = ST_SCAN;
            end
            ST_SCAN: begin
                scan_ctl.step  = 1'b1;
                scan_ctl.first = (way_reg == '0);
                if (way_reg == WAY_W'(ways_c - 1'b1)) begin
                    state_next = ST_FINISH;
                end else begin
                    line_rd_en = 1'b1;
                    way_next   = WAY_W'(way_reg + 1'b1);
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    finish     = 1'b1;
                    line_we    = 1'b1;
                    vrow_we    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        way_reg     <= way_next;
        shifted_reg <= shifted_next;
        op_reg      <= op_next;
        set_reg     <= set_next;
        tag_reg     <= tag_next;
    end

    // ------------------------------------------------------------------
    // Line store. Tag and stamp only matter for lines whose valid bit is
    // set, so they need no clearing.
    // ------------------------------------------------------------------
    assign line_rd_addr = LINE_W'(line_rd_set) * LINE_W'(MAX_WAYS) + LINE_W'(line_rd_way);
    assign line_wr_addr = LINE_W'(set_reg) * LINE_W'(MAX_WAYS) + LINE_W'(pick_way);
    assign pick_bit     = MAX_WAYS'(1) << pick_way;

    always_ff @(posedge aclk) begin
        if (line_we) begin
            tag_mem[line_wr_addr]   <= tag_reg;
            stamp_mem[line_wr_addr] <= access_cnt_reg;
        end
        if (line_rd_en) begin
            rd_tag_reg   <= tag_mem[line_rd_addr];
            rd_stamp_reg <= stamp_mem[line_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (vrow_we) begin
            vrow_mem[vrow_wr_addr] <= vrow_wr_data;
        end
        if (vrow_rd_en) begin
            vrow_reg <= vrow_mem[vrow_rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Shared compare unit, stepped once per way.
    // ------------------------------------------------------------------
    salc_scan_unit #(
        .MAX_WAYS   (MAX_WAYS),
        .STAMP_BITS (STAMP_BITS),
        .WAY_W      (WAY_W)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (scan_ctl),
        .way        (way_reg),
        .line_valid (vrow_reg[way_reg]),
        .line_tag   (rd_tag_reg),
        .ref_tag    (tag_reg),
        .line_stamp (rd_stamp_reg),
        .now        (access_cnt_reg),
        .status     (scan_stat),
        .pick_way   (pick_way)
    );

    // ------------------------------------------------------------------
    // Totals. A modify counts one extra hit for its store half; every total
    // saturates at all ones.
    // ------------------------------------------------------------------
    assign modify  = (op_reg == OP_MODIFY);
    assign evicted = !scan_stat.hit && !scan_stat.free;
    assign hit_inc = {1'b0, scan_stat.hit} + {1'b0, modify};

    assign hit_sum   = {1'b0, hit_cnt_reg} + (CNT_W + 1)'(hit_inc);
    assign miss_sum  = {1'b0, miss_cnt_reg} + (CNT_W + 1)'(!scan_stat.hit);
    assign evict_sum = {1'b0, evict_cnt_reg} + (CNT_W + 1)'(evicted);

    assign hit_cnt_next   = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
    assign miss_cnt_next  = miss_sum[CNT_W] ? '1 : miss_sum[CNT_W-1:0];
    assign evict_cnt_next = evict_sum[CNT_W] ? '1 : evict_sum[CNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            access_cnt_reg <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            evict_cnt_reg  <= '0;
        end else if (finish) begin
            access_cnt_reg <= access_cnt_reg + 1'b1;
            hit_cnt_reg    <= hit_cnt_next;
            miss_cnt_reg   <= miss_cnt_next;
            evict_cnt_reg  <= evict_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register. The totals only move when a new result is loaded, so
    // they are shown straight from the counters.
    // ------------------------------------------------------------------
    assign m_valid_next = finish ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_hit_reg        <= scan_stat.hit;
            m_eviction_reg   <= evicted;
            m_modify_hit_reg <= modify;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_hit             = m_hit_reg;
    assign m_eviction        = m_eviction_reg;
    assign m_modify_hit      = m_modify_hit_reg;
    assign m_total_hits      = hit_cnt_reg;
    assign m_total_misses    = miss_cnt_reg;
    assign m_total_evictions = evict_cnt_reg;

endmodule

`default_nettype wire

// ----- verif/set_assoc_lru_cache_sim_test.sv -----
// Self-checking testbench for the set-associative LRU cache model.
`default_nettype none

module set_assoc_lru_cache_sim_test;
    import salc_pkg::*;

    // The unused access kind has no name in the package, but it behaves as a load.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int NUM_LINES     = (1 << DEF_MAX_SET_BITS) * DEF_MAX_WAYS;
    // Extra settling time given to the block before any register write or
    // before the final verdict.
    localparam int SETTLE_CYCLES = DEF_MAX_WAYS + 3 + 8;
    // Room for roughly 600 words plus the clearing pass after reset, taken
    // several times over.
    localparam int CYCLE_LIMIT   = 300000;
    localparam int WORDS_PER_PHASE = 68;
    localparam int RANDOM_PHASES   = 8;
    localparam int PRINT_CAP       = 50;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
    } access_word_t;

    typedef struct packed {
        logic             hit;
        logic             eviction;
        logic             modify_hit;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] evictions;
    } cache_result_t;

    // Every block input starts at a known value at time zero.
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [OP_W-1:0]      s_opcode  = '0;
    logic [ADDR_W-1:0]    s_address = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic                 m_hit;
    logic                 m_eviction;
    logic                 m_modify_hit;
    logic [CNT_W-1:0]     m_total_hits;
    logic [CNT_W-1:0]     m_total_misses;
    logic [CNT_W-1:0]     m_total_evictions;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    set_assoc_lru_cache_sim DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_address         (s_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_hit             (m_hit),
        .m_eviction        (m_eviction),
        .m_modify_hit      (m_modify_hit),
        .m_total_hits      (m_total_hits),
        .m_total_misses    (m_total_misses),
        .m_total_evictions (m_total_evictions),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    // Words waiting to be driven, and results the cache is expected to return.
    access_word_t  pending_words[$];
    cache_result_t expected_results[$];

    // Our own copy of the cache: line store, access clock and totals.
    logic                      shadow_valid [NUM_LINES];
    logic [TAG_W-1:0]          shadow_tag   [NUM_LINES];
    logic [DEF_STAMP_BITS-1:0] shadow_stamp [NUM_LINES];
    logic [DEF_STAMP_BITS-1:0] shadow_clock;
    logic [CNT_W-1:0]          shadow_hits;
    logic [CNT_W-1:0]          shadow_misses;
    logic [CNT_W-1:0]          shadow_evicts;

    // Our copy of the configuration registers, as last written.
    logic [SETB_W-1:0]  cfg_set_bits = RST_SET_BITS;
    logic [WAYSR_W-1:0] cfg_ways     = RST_WAYS;
    logic [OFFB_W-1:0]  cfg_offset   = RST_OFFSET_BITS;

    int error_count   = 0;
    int words_sent    = 0;
    int results_seen  = 0;
    int hits_seen     = 0;
    int evicts_seen   = 0;
    int settings_used = 1;
    int cycle_count   = 0;

    // Sender burst state and receiver stall state.
    int burst_left   = 1;
    int gap_left     = 0;
    int stall_mode   = 0;
    int stall_window = 0;
    access_word_t  next_word;
    cache_result_t want;

    // Registers read out of range are pulled back into the legal span.
    function automatic int eff_set_bits();
        if (cfg_set_bits == 0) return 1;
        if (cfg_set_bits > DEF_MAX_SET_BITS) return DEF_MAX_SET_BITS;
        return int'(cfg_set_bits);
    endfunction

    function automatic int eff_ways();
        if (cfg_ways == 0) return 1;
        if (cfg_ways > DEF_MAX_WAYS) return DEF_MAX_WAYS;
        return int'(cfg_ways);
    endfunction

    function automatic int eff_offset();
        if (cfg_offset == 0) return 1;
        return int'(cfg_offset);
    endfunction

    function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] a, input int inc);
        logic [CNT_W:0] s;
        s = {1'b0, a} + (CNT_W + 1)'(inc);
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    // Looks up one access in the shadow cache, updates it exactly as the
    // cache does, and returns the result word the cache should produce.
    function automatic cache_result_t predict_access(input logic [OP_W-1:0] op,
                                                     input logic [ADDR_W-1:0] addr);
        int sbits, ways, obits, base, pick, w;
        logic [ADDR_W-1:0] set_no, shifted;
        logic [TAG_W-1:0] tag;
        logic [DEF_STAMP_BITS-1:0] age, oldest;
        logic hit, found, evicted, modify;
        cache_result_t r;
        sbits   = eff_set_bits();
        ways    = eff_ways();
        obits   = eff_offset();
        set_no  = (addr >> obits) & ((64'd1 << sbits) - 64'd1);
        shifted = addr >> (sbits + obits);
        tag     = (sbits + obits >= ADDR_W) ? '0 : shifted[TAG_W-1:0];
        base    = int'(set_no) * DEF_MAX_WAYS;
        hit     = 1'b0;
        found   = 1'b0;
        evicted = 1'b0;
        pick    = 0;
        modify  = (op == OP_MODIFY);
        for (w = 0; w < ways; w++) begin
            if (!hit && shadow_valid[base + w] && shadow_tag[base + w] == tag) begin
                hit  = 1'b1;
                pick = w;
            end
        end
        if (!hit) begin
            for (w = 0; w < ways; w++) begin
                if (!found && !shadow_valid[base + w]) begin
                    found = 1'b1;
                    pick  = w;
                end
            end
            // Every way in use is full: replace the oldest, lowest way on a tie.
            if (!found) begin
                evicted = 1'b1;
                oldest  = '0;
                for (w = 0; w < ways; w++) begin
                    age = shadow_clock - shadow_stamp[base + w];
                    if (w == 0 || age > oldest) begin
                        oldest = age;
                        pick   = w;
                    end
                end
            end
        end
        shadow_valid[base + pick] = 1'b1;
        shadow_tag[base + pick]   = tag;
        shadow_stamp[base + pick] = shadow_clock;
        shadow_clock  = shadow_clock + 1'b1;
        shadow_hits   = sat_bump(shadow_hits, int'(hit) + int'(modify));
        shadow_misses = sat_bump(shadow_misses, hit ? 0 : 1);
        shadow_evicts = sat_bump(shadow_evicts, evicted ? 1 : 0);
        r.hit        = hit;
        r.eviction   = evicted;
        r.modify_hit = modify;
        r.hits       = shadow_hits;
        r.misses     = shadow_misses;
        r.evictions  = shadow_evicts;
        return r;
    endfunction

    // Builds an address from a tag, set and offset under the current split.
    function automatic logic [ADDR_W-1:0] make_address(input logic [TAG_W-1:0] tag,
                                                       input int set_no,
                                                       input logic [ADDR_W-1:0] low);
        int sbits, obits;
        logic [ADDR_W-1:0] a, sv;
        sbits = eff_set_bits();
        obits = eff_offset();
        sv    = ADDR_W'(unsigned'(set_no));
        a     = {{(ADDR_W-TAG_W){1'b0}}, tag} << (sbits + obits);
        a     = a | ((sv & ((64'd1 << sbits) - 64'd1)) << obits);
        return a | (low & ((64'd1 << obits) - 64'd1));
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
        if (error_count < PRINT_CAP)
            $display("mismatch at result %0d: %s got %0h, expected %0h",
                     results_seen, what, got, exp_val);
        error_count++;
    endtask

    task automatic queue_access(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
        access_word_t wd;
        wd.op   = op;
        wd.addr = addr;
        pending_words.push_back(wd);
    endtask

    // One register write; the shadow copy is updated as the write is driven. Only
    // called while the cache is idle, so no access sees a half-changed setup.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_SET_BITS:    cfg_set_bits = val[SETB_W-1:0];
            REG_WAYS:        cfg_ways     = val[WAYSR_W-1:0];
            REG_OFFSET_BITS: cfg_offset   = val[OFFB_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every queued word has gone in and every result has come
    // back, then lets the pipeline settle.
    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_words.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Driver. A word is predicted at the edge where the cache takes it. A new
    // word is offered only once the previous one has gone, so valid stays up
    // with a stable payload until it is accepted. The sender works in bursts
    // of random length separated by random gaps; some gaps are zero so that
    // long back-to-back stretches occur as well.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_access(s_opcode, s_address));
                words_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    next_word = pending_words.pop_front();
                    s_valid   <= 1'b1;
                    s_opcode  <= next_word.op;
                    s_address <= next_word.addr;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Each accepted result is checked field by field against the
    // oldest prediction. The receiver stalls on a pattern of its own: it
    // switches between always ready, coin-flip ready and mostly stalled, in
    // windows of random length.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    flag_mismatch("result word with nothing expected", 64'd0, 64'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_hit !== want.hit)
                        flag_mismatch("hit", 64'(m_hit), 64'(want.hit));
                    if (m_eviction !== want.eviction)
                        flag_mismatch("eviction", 64'(m_eviction), 64'(want.eviction));
                    if (m_modify_hit !== want.modify_hit)
                        flag_mismatch("modify_hit", 64'(m_modify_hit), 64'(want.modify_hit));
                    if (m_total_hits !== want.hits)
                        flag_mismatch("total_hits", 64'(m_total_hits), 64'(want.hits));
                    if (m_total_misses !== want.misses)
                        flag_mismatch("total_misses", 64'(m_total_misses), 64'(want.misses));
                    if (m_total_evictions !== want.evictions)
                        flag_mismatch("total_evictions", 64'(m_total_evictions),
                                      64'(want.evictions));
                    if (want.hit) hits_seen++;
                    if (want.eviction) evicts_seen++;
                end
            end
            if (stall_window == 0) begin
                stall_mode   = $urandom_range(0, 2);
                stall_window = $urandom_range(16, 80);
            end else begin
                stall_window--;
            end
            case (stall_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, expected_results.size());
            $display("set_assoc_lru_cache_sim_test: done, errors");
            $finish;
        end
    end

    // Stimulus. Reset once, a short directed part, then random phases, each
    // under its own register setting written while the cache is idle.
    initial begin
        int p, k, n, pick_r, hot_sets, sbits_v, ways_v, offs_v;
        logic [TAG_W-1:0] tag_pool [16];
        logic [ADDR_W-1:0] rnd;

        for (k = 0; k < NUM_LINES; k++) begin
            shadow_valid[k] = 1'b0;
            shadow_tag[k]   = '0;
            shadow_stamp[k] = '0;
        end
        shadow_clock  = '0;
        shadow_hits   = '0;
        shadow_misses = '0;
        shadow_evicts = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset setup (4 set bits, one way, 4 offset bits): fill, hit from
        // every access kind, the unused kind acting as a load, a conflict
        // that evicts from a one-way set, and the extreme addresses.
        queue_access(OP_LOAD,   64'h0);
        queue_access(OP_LOAD,   64'h0);
        queue_access(OP_STORE,  64'h8);
        queue_access(OP_MODIFY, 64'h0);
        queue_access(OP_MODIFY, 64'h100);
        queue_access(OP_SPARE,  64'h100);
        queue_access(OP_LOAD,   {ADDR_W{1'b1}});
        queue_access(OP_STORE,  {ADDR_W{1'b1}});
        queue_access(OP_LOAD,   64'h8000_0000_0000_0000);
        queue_access(OP_MODIFY, {ADDR_W{1'b1}});
        wait_idle();

        // Four ways in a two-set cache: fill a set, refresh the first line,
        // then two misses that must pick the least recently used ways.
        write_reg(REG_SET_BITS, 6'd1);
        write_reg(REG_WAYS, 6'd4);
        write_reg(REG_OFFSET_BITS, 6'd1);
        settings_used++;
        for (k = 1; k <= 4; k++) queue_access(OP_LOAD, make_address(TAG_W'(k), 0, 64'd0));
        queue_access(OP_LOAD,  make_address(TAG_W'(1), 0, 64'd1));
        queue_access(OP_STORE, make_address(TAG_W'(5), 0, 64'd0));
        queue_access(OP_LOAD,  make_address(TAG_W'(2), 0, 64'd1));
        wait_idle();

        // Shrink to two ways: lines in the upper ways are invisible but kept,
        // and reappear once the full width is back.
        write_reg(REG_WAYS, 6'd2);
        settings_used++;
        queue_access(OP_LOAD,  make_address(TAG_W'(4), 0, 64'd0));
        queue_access(OP_STORE, make_address(TAG_W'(3), 0, 64'd0));
        wait_idle();
        write_reg(REG_WAYS, 6'd4);
        settings_used++;
        queue_access(OP_LOAD,   make_address(TAG_W'(4), 0, 64'd0));
        queue_access(OP_MODIFY, make_address(TAG_W'(2), 0, 64'd0));
        wait_idle();

        // Random phases. The first ones hit the register extremes (zero acts
        // as one, values above the maximum clamp), the last ones are random.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin sbits_v = 0;  ways_v = 0;  offs_v = 0;  end
                1: begin sbits_v = 15; ways_v = 15; offs_v = 63; end
                2: begin sbits_v = 8;  ways_v = 8;  offs_v = 32; end
                3: begin sbits_v = 1;  ways_v = 8;  offs_v = 1;  end
                4: begin sbits_v = 2;  ways_v = 3;  offs_v = 60; end
                5: begin sbits_v = 4;  ways_v = 6;  offs_v = 10; end
                default: begin
                    sbits_v = $urandom_range(0, 15);
                    ways_v  = $urandom_range(0, 15);
                    offs_v  = $urandom_range(0, 63);
                end
            endcase
            write_reg(REG_SET_BITS, CFG_W'(sbits_v));
            write_reg(REG_WAYS, CFG_W'(ways_v));
            write_reg(REG_OFFSET_BITS, CFG_W'(offs_v));
            settings_used++;

            // A pool a little larger than the set keeps both hits and LRU
            // evictions frequent; half the tags are small, half use all bits.
            n = eff_ways() + 3;
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 1)) tag_pool[k] = TAG_W'(k + 1);
                else tag_pool[k] = TAG_W'({$urandom, $urandom});
            end
            hot_sets = (eff_set_bits() >= 2) ? 4 : (1 << eff_set_bits());

            for (k = 0; k < WORDS_PER_PHASE; k++) begin
                pick_r = $urandom_range(0, 99);
                rnd    = {$urandom, $urandom};
                if (pick_r < 85) begin
                    queue_access(OP_W'($urandom_range(0, 3)),
                                 make_address(tag_pool[$urandom_range(0, n - 1)],
                                              $urandom_range(0, hot_sets - 1), rnd));
                end else begin
                    // Noise: a fully random address, mostly a cold miss.
                    queue_access(OP_W'($urandom_range(0, 3)), rnd);
                end
            end
            wait_idle();
        end

        $display("run covered %0d words and %0d results under %0d register settings",
                 words_sent, results_seen, settings_used);
        $display("results included %0d hits and %0d evictions; %0d mismatches",
                 hits_seen, evicts_seen, error_count);
        if (error_count == 0) begin
            $display("set_assoc_lru_cache_sim_test: done, clean");
        end else begin
            $display("set_assoc_lru_cache_sim_test: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
